// ===== rtl/vht_pkg.sv =====
`timescale 1ns / 1ps

package vht_pkg;

  // Counter store
  localparam int unsigned MaxImages = 1024;
  localparam int unsigned AddrW     = $clog2(MaxImages);
  localparam int unsigned ImgCntW   = AddrW + 1;
  localparam int unsigned CountW    = 16;

  // Report length
  localparam int unsigned MaxSimilar = 16;

  // Field widths
  localparam int unsigned ImageW    = 10;
  localparam int unsigned RankW     = 4;
  localparam int unsigned NumImgW   = 11;
  localparam int unsigned NumSimW   = 5;

  // Configuration port
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 11;

  localparam logic [CfgIdxW-1:0] CfgNumImages  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNumSimilar = 2'd1;

  localparam logic ModeHit    = 1'b0;
  localparam logic ModeReport = 1'b1;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StScan,
    StPick
  } vht_state_e;

  typedef struct packed {
    logic hit_take;
    logic scan_init;
    logic scan_issue;
    logic pick_commit;
    logic clear_step;
  } vht_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic rd_pend;
    logic out_free;
    logic last_rank;
    logic clear_last;
  } vht_status_t;

endpackage

// ===== rtl/vht_in_if.sv =====
`timescale 1ns / 1ps

interface vht_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [vht_pkg::ImageW-1:0]     image_index;

  modport source (output valid, mode, image_index, input ready);
  modport sink   (input valid, mode, image_index, output ready);
endinterface

// ===== rtl/vht_out_if.sv =====
`timescale 1ns / 1ps

interface vht_out_if;
  logic                           valid;
  logic                           ready;
  logic [vht_pkg::RankW-1:0]      rank;
  logic [vht_pkg::ImageW-1:0]     best_image;
  logic                           found;
  logic                           last;

  modport source (output valid, rank, best_image, found, last, input ready);
  modport sink   (input valid, rank, best_image, found, last, output ready);
endinterface

// ===== rtl/vht_cfg_if.sv =====
`timescale 1ns / 1ps

interface vht_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [vht_pkg::CfgIdxW-1:0]    index;
  logic [vht_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/vote_histogram_top_n.sv =====
`timescale 1ns / 1ps

// Vote histogram with top-N report. A hit transaction (mode 0) bumps a
// saturating 16-bit counter held in a 1024-entry single-port-write RAM; hits
// are taken one per cycle while the block is idle, the counter read being
// registered in the RAM and the new count written back from stage s1, with the
// count carried over when the same image is hit twice in a row. A report
// transaction (mode 1) runs num_similar scans (clamped to 1..16), one counter
// read per cycle over the num_images counters in use. The block then zeroes
// all 1024 counters, one per cycle, before it takes the next transaction, as
// it also does after reset. Configuration writes are taken at any time and
// are meant for when the block is idle. Results sit in an output register, so
// a scan carries on while the previous result waits to be taken.
module vote_histogram_top_n (
  input  logic       clk_i,
  input  logic       rst_ni,
  vht_in_if.sink     in_i,
  vht_out_if.source  out_o,
  vht_cfg_if.sink    cfg_i
);

  vht_pkg::vht_cmd_t    cmd;
  vht_pkg::vht_status_t status;

  assign cfg_i.ready = 1'b1;

  vht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vht_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .in_image_index_i (in_i.image_index),
    .cfg_valid_i      (cfg_i.valid),
    .cfg_index_i      (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .out_rank_o       (out_o.rank),
    .out_best_image_o (out_o.best_image),
    .out_found_o      (out_o.found),
    .out_last_o       (out_o.last)
  );

endmodule

// ===== rtl/vht_ram.sv =====
`timescale 1ns / 1ps

module vht_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/vht_ctrl.sv =====
`timescale 1ns / 1ps

module vht_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_mode_i,
  output logic                 in_ready_o,
  input  vht_pkg::vht_status_t status_i,
  output vht_pkg::vht_cmd_t    cmd_o
);

  vht_pkg::vht_state_e state_q, state_d;
  logic                in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vht_pkg::StClear;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_take = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      vht_pkg::StClear: begin
        // sweep zeros through the whole store, after reset and after a report
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) begin
          state_d = vht_pkg::StIdle;
        end
      end
      vht_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_take) begin
          if (in_mode_i == vht_pkg::ModeReport) begin
            cmd_o.scan_init = 1'b1;
            state_d         = vht_pkg::StScan;
          end else begin
            cmd_o.hit_take = 1'b1;
          end
        end
      end
      vht_pkg::StScan: begin
        if (!status_i.scan_end) begin
          cmd_o.scan_issue = 1'b1;
        end else if (!status_i.rd_pend) begin
          state_d = vht_pkg::StPick;
        end
      end
      vht_pkg::StPick: begin
        if (status_i.out_free) begin
          cmd_o.pick_commit = 1'b1;
          state_d = status_i.last_rank ? vht_pkg::StClear : vht_pkg::StScan;
        end
      end
      default: begin
        state_d = vht_pkg::StClear;
      end
    endcase
  end

endmodule

// ===== rtl/vht_datapath.sv =====
`timescale 1ns / 1ps

module vht_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  vht_pkg::vht_cmd_t              cmd_i,
  output vht_pkg::vht_status_t           status_o,
  input  logic [vht_pkg::ImageW-1:0]     in_image_index_i,
  input  logic                           cfg_valid_i,
  input  logic [vht_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [vht_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [vht_pkg::RankW-1:0]      out_rank_o,
  output logic [vht_pkg::ImageW-1:0]     out_best_image_o,
  output logic                           out_found_o,
  output logic                           out_last_o
);

  localparam int unsigned AddrW   = vht_pkg::AddrW;
  localparam int unsigned ImgCntW = vht_pkg::ImgCntW;
  localparam int unsigned CountW  = vht_pkg::CountW;
  localparam int unsigned NumSimW = vht_pkg::NumSimW;
  localparam int unsigned RankW   = vht_pkg::RankW;

  // Configuration
  logic [vht_pkg::NumImgW-1:0] num_images_q;
  logic [NumSimW-1:0]          num_similar_q;
  logic [ImgCntW-1:0]          used;
  logic [NumSimW-1:0]          similar;

  // Hit pipeline
  logic                        s1_valid_q;
  logic [AddrW-1:0]            s1_addr_q;
  logic                        fwd_valid_q;
  logic [AddrW-1:0]            fwd_addr_q;
  logic [CountW-1:0]           fwd_data_q;
  logic                        hit_in_range;
  logic [CountW-1:0]           cur_cnt;
  logic [CountW-1:0]           inc_cnt;

  // Scan
  logic [ImgCntW-1:0]          addr_q;
  logic                        rd_pend_q;
  logic [AddrW-1:0]            rd_addr_q;
  logic [CountW-1:0]           best_cnt_q;
  logic [AddrW-1:0]            best_idx_q;
  logic [RankW-1:0]            rank_q;
  logic                        found;

  // Memory ports
  logic                        ram_re;
  logic [AddrW-1:0]            ram_raddr;
  logic [CountW-1:0]           ram_rdata;
  logic                        ram_we;
  logic [AddrW-1:0]            ram_waddr;
  logic [CountW-1:0]           ram_wdata;

  // Output register
  logic                        out_valid_q;
  logic [RankW-1:0]            out_rank_q;
  logic [vht_pkg::ImageW-1:0]  out_best_image_q;
  logic                        out_found_q;
  logic                        out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_images_q  <= vht_pkg::NumImgW'(vht_pkg::MaxImages);
      num_similar_q <= NumSimW'(1);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == vht_pkg::CfgNumImages) begin
        num_images_q <= cfg_data_i[vht_pkg::NumImgW-1:0];
      end else if (cfg_index_i == vht_pkg::CfgNumSimilar) begin
        num_similar_q <= cfg_data_i[NumSimW-1:0];
      end
    end
  end

  assign used = (num_images_q > vht_pkg::NumImgW'(vht_pkg::MaxImages)) ?
                ImgCntW'(vht_pkg::MaxImages) : ImgCntW'(num_images_q);

  always_comb begin
    if (num_similar_q == '0) begin
      similar = NumSimW'(1);
    end else if (num_similar_q > NumSimW'(vht_pkg::MaxSimilar)) begin
      similar = NumSimW'(vht_pkg::MaxSimilar);
    end else begin
      similar = num_similar_q;
    end
  end

  assign hit_in_range = ImgCntW'(in_image_index_i) < used;

  // A read issued in the same cycle as the previous hit's write sees the old
  // count, so the just-written value is carried over from fwd_data_q.
  assign cur_cnt = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : ram_rdata;
  assign inc_cnt = (cur_cnt == '1) ? cur_cnt : cur_cnt + CountW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= cmd_i.hit_take && hit_in_range;
      fwd_valid_q <= s1_valid_q && cmd_i.hit_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hit_take) begin
      s1_addr_q <= AddrW'(in_image_index_i);
    end
    if (s1_valid_q) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= inc_cnt;
    end
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = addr_q[AddrW-1:0];
    if (cmd_i.hit_take) begin
      ram_re    = 1'b1;
      ram_raddr = AddrW'(in_image_index_i);
    end else if (cmd_i.scan_issue) begin
      ram_re    = 1'b1;
    end
  end

  assign found = best_cnt_q != '0;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q[AddrW-1:0];
    ram_wdata = '0;
    if (s1_valid_q) begin
      ram_we    = 1'b1;
      ram_waddr = s1_addr_q;
      ram_wdata = inc_cnt;
    end else if (cmd_i.clear_step) begin
      ram_we    = 1'b1;
    end else if (cmd_i.pick_commit) begin
      // take the winner out of the later scans
      ram_we    = found;
      ram_waddr = best_idx_q;
    end
  end

  vht_ram #(
    .Width (CountW),
    .Depth (vht_pkg::MaxImages)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      rd_pend_q <= 1'b0;
      rank_q    <= '0;
    end else begin
      rd_pend_q <= cmd_i.scan_issue;
      if (cmd_i.scan_init) begin
        addr_q <= '0;
        rank_q <= '0;
      end else if (cmd_i.pick_commit) begin
        addr_q <= '0;
        rank_q <= rank_q + RankW'(1);
      end else if (cmd_i.scan_issue) begin
        addr_q <= addr_q + ImgCntW'(1);
      end else if (cmd_i.clear_step) begin
        addr_q <= status_o.clear_last ? '0 : addr_q + ImgCntW'(1);
      end
    end
  end

  // strict greater-than keeps the lowest index on a tie
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_issue) begin
      rd_addr_q <= addr_q[AddrW-1:0];
    end
    if (cmd_i.scan_init || cmd_i.pick_commit) begin
      best_cnt_q <= '0;
      best_idx_q <= '0;
    end else if (rd_pend_q && (ram_rdata > best_cnt_q)) begin
      best_cnt_q <= ram_rdata;
      best_idx_q <= rd_addr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.pick_commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pick_commit) begin
      out_rank_q       <= rank_q;
      out_best_image_q <= found ? vht_pkg::ImageW'(best_idx_q) : '0;
      out_found_q      <= found;
      out_last_q       <= status_o.last_rank;
    end
  end

  assign status_o.scan_end   = addr_q >= used;
  assign status_o.rd_pend    = rd_pend_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign status_o.last_rank  = NumSimW'(rank_q) == (similar - NumSimW'(1));
  assign status_o.clear_last = addr_q == ImgCntW'(vht_pkg::MaxImages - 1);

  assign out_valid_o      = out_valid_q;
  assign out_rank_o       = out_rank_q;
  assign out_best_image_o = out_best_image_q;
  assign out_found_o      = out_found_q;
  assign out_last_o       = out_last_q;

endmodule

// ===== tb/tb_vote_histogram_top_n.sv =====
`timescale 1ns / 1ps

module tb_vote_histogram_top_n;
  import vht_pkg::*;

  localparam int unsigned IdlePct       = 28;
  localparam int unsigned SettleCycles  = MaxImages + 16;
  localparam int unsigned Phases        = 10;
  localparam int unsigned ItemsPerPhase = 48;
  localparam int unsigned ShownMax      = 10;

  // index with no register behind it, writes are dropped
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  typedef struct packed {
    logic [RankW-1:0]  rank;
    logic [ImageW-1:0] best_image;
    logic              found;
    logic              last;
  } ranking_t;

  typedef enum logic [1:0] {
    RowHit,
    RowReport,
    RowCfg
  } drill_kind_e;

  typedef struct packed {
    drill_kind_e         kind;
    logic [CfgIdxW-1:0]  cfg_reg;
    logic [CfgDataW-1:0] value;
    logic [16:0]         reps;
    logic                typed;
    logic [ImageW-1:0]   exp_best;
    logic                exp_found;
  } drill_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   calm  = 1'b0;

  vht_in_if  vote_in ();
  vht_out_if rank_out ();
  vht_cfg_if cfg_bus ();

  vote_histogram_top_n i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (vote_in),
    .out_o  (rank_out),
    .cfg_i  (cfg_bus)
  );

  // predictor state
  logic [CountW-1:0]  vote_tally [MaxImages];
  logic [NumImgW-1:0] cfg_images;
  logic [NumSimW-1:0] cfg_similar;
  ranking_t           ranking_q [$];

  int unsigned mismatches     = 0;
  int unsigned hits_sent      = 0;
  int unsigned hits_ignored   = 0;
  int unsigned reports_sent   = 0;
  int unsigned results_seen   = 0;
  int unsigned settings_tried = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic log_mismatch(input string what, input int unsigned want_v,
                              input int unsigned got_v);
    mismatches++;
    if (mismatches <= ShownMax) begin
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want_v, got_v);
    end
  endtask

  // works out the results of one accepted transaction and updates the tally
  task automatic apply_vote(input logic mode, input logic [ImageW-1:0] idx);
    int unsigned used;
    int unsigned n;
    int unsigned pick;
    logic [CountW-1:0] top;
    logic found;
    ranking_t res;
    used = (cfg_images > MaxImages) ? MaxImages : 32'(cfg_images);
    if (mode == ModeHit) begin
      hits_sent++;
      if (32'(idx) < used) begin
        if (vote_tally[idx] != '1) vote_tally[idx] = vote_tally[idx] + 1'b1;
      end else begin
        hits_ignored++;
      end
    end else begin
      reports_sent++;
      if (cfg_similar == '0) n = 1;
      else n = (cfg_similar > MaxSimilar) ? MaxSimilar : 32'(cfg_similar);
      for (int unsigned r = 0; r < n; r++) begin
        top   = '0;
        pick  = 0;
        found = 1'b0;
        for (int unsigned j = 0; j < used; j++) begin
          if (vote_tally[j] > top) begin
            top   = vote_tally[j];
            pick  = j;
            found = 1'b1;
          end
        end
        if (found) vote_tally[pick] = '0;
        res.rank       = RankW'(r);
        res.best_image = found ? ImageW'(pick) : '0;
        res.found      = found;
        res.last       = (r + 1 == n);
        ranking_q.push_back(res);
      end
      foreach (vote_tally[j]) vote_tally[j] = '0;
    end
  endtask

  // leaves valid high after the transaction; the next call drives it anew and a drain lowers it
  task automatic send_vote(input logic mode, input logic [ImageW-1:0] idx);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      vote_in.valid <= 1'b0;
      @(posedge clk);
    end
    vote_in.valid       <= 1'b1;
    vote_in.mode        <= mode;
    vote_in.image_index <= idx;
    @(posedge clk);
    while (!vote_in.ready) @(posedge clk);
    apply_vote(mode, idx);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data,
                           input bit more);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (!more) cfg_bus.valid <= 1'b0;
    case (idx)
      CfgNumImages:  cfg_images  = data;
      CfgNumSimilar: cfg_similar = data[NumSimW-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained(input bit settle);
    vote_in.valid <= 1'b0;
    while (ranking_q.size() != 0) @(posedge clk);
    if (settle) repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic drill_t hit_row(input int unsigned idx, input int unsigned reps);
    drill_t d;
    d       = '0;
    d.kind  = RowHit;
    d.value = CfgDataW'(idx);
    d.reps  = 17'(reps);
    return d;
  endfunction

  function automatic drill_t report_row(input bit typed, input int unsigned best,
                                        input bit found);
    drill_t d;
    d           = '0;
    d.kind      = RowReport;
    d.typed     = typed;
    d.exp_best  = ImageW'(best);
    d.exp_found = found;
    return d;
  endfunction

  function automatic drill_t cfg_row(input logic [CfgIdxW-1:0] idx, input int unsigned data);
    drill_t d;
    d         = '0;
    d.kind    = RowCfg;
    d.cfg_reg = idx;
    d.value   = CfgDataW'(data);
    return d;
  endfunction

  always @(posedge clk) begin
    ranking_t seen;
    ranking_t want;
    rank_out.ready <= calm || ($urandom_range(0, 99) >= IdlePct);
    if (rst_n && rank_out.valid && rank_out.ready) begin
      seen.rank       = rank_out.rank;
      seen.best_image = rank_out.best_image;
      seen.found      = rank_out.found;
      seen.last       = rank_out.last;
      results_seen++;
      if (ranking_q.size() == 0) begin
        log_mismatch("result with no report pending, rank", 0, seen.rank);
      end else begin
        want = ranking_q.pop_front();
        if (seen.rank != want.rank) log_mismatch("rank", want.rank, seen.rank);
        if (seen.best_image != want.best_image) begin
          log_mismatch($sformatf("rank %0d best_image", want.rank), want.best_image,
                       seen.best_image);
        end
        if (seen.found != want.found) begin
          log_mismatch($sformatf("rank %0d found", want.rank), want.found, seen.found);
        end
        if (seen.last != want.last) begin
          log_mismatch($sformatf("rank %0d last", want.rank), want.last, seen.last);
        end
      end
    end
  end

  initial begin
    drill_t              drill [$];
    ranking_t            typed_exp;
    int unsigned         left;
    int unsigned         burst;
    int unsigned         imgs;
    logic [ImageW-1:0]   idx;
    logic [CfgDataW-1:0] sim_word;
    bit                  big;

    vote_in.valid       <= 1'b0;
    vote_in.mode        <= ModeHit;
    vote_in.image_index <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= CfgNumImages;
    cfg_bus.data        <= '0;
    foreach (vote_tally[j]) vote_tally[j] = '0;
    cfg_images  = NumImgW'(MaxImages);
    cfg_similar = NumSimW'(1);

    // report length stays at one wherever the result is typed in
    drill = '{
      report_row(1, 0, 0),
      hit_row(1023, 1), hit_row(0, 1), report_row(1, 0, 1),
      // two hits on 5 outweigh the single hit on the lower index 3
      hit_row(5, 2), hit_row(3, 1), report_row(1, 5, 1),
      hit_row(900, 1),
      cfg_row(CfgNumImages, 4),
      report_row(1, 0, 0),
      hit_row(4, 1), hit_row(3, 1), report_row(1, 3, 1),
      cfg_row(CfgNumImages, 0),
      hit_row(0, 1), report_row(1, 0, 0),
      cfg_row(CfgNumImages, 2047),
      report_row(1, 0, 0),
      hit_row(1023, 1), report_row(1, 1023, 1),
      cfg_row(CfgNumSimilar, 0),
      hit_row(2, 1), report_row(1, 2, 1),
      cfg_row(CfgNumSimilar, 16),
      hit_row(7, 1), hit_row(7, 1), hit_row(9, 1), report_row(0, 0, 0),
      cfg_row(CfgNumSimilar, 31),
      hit_row(1, 1), report_row(0, 0, 0)
    };

    @(posedge clk);
    while (!rst_n) @(posedge clk);

    foreach (drill[i]) begin
      case (drill[i].kind)
        RowCfg: begin
          wait_drained(1'b1);
          write_reg(drill[i].cfg_reg, drill[i].value, 1'b0);
          settings_tried++;
        end
        RowHit: begin
          calm = (drill[i].reps > 1);
          repeat (drill[i].reps) send_vote(ModeHit, drill[i].value[ImageW-1:0]);
          calm = 1'b0;
        end
        default: begin
          send_vote(ModeReport, ImageW'($urandom));
          if (drill[i].typed) begin
            typed_exp            = ranking_q.pop_back();
            typed_exp.best_image = drill[i].exp_best;
            typed_exp.found      = drill[i].exp_found;
            ranking_q.push_back(typed_exp);
          end
        end
      endcase
    end

    for (int unsigned p = 0; p < Phases; p++) begin
      big  = (p == 3);
      imgs = big ? MaxImages : ((p == 6) ? 1 : $urandom_range(2, 40));
      if (p == 1) sim_word = CfgDataW'(MaxSimilar);
      else if (p == 6) sim_word = CfgDataW'(1);
      else sim_word = CfgDataW'($urandom_range(1, MaxSimilar));
      // bits above the register width must be dropped
      if (p % 3 == 2) sim_word[CfgDataW-1:NumSimW] = (CfgDataW - NumSimW)'($urandom);

      wait_drained(1'b1);
      if (p == 5) write_reg(CfgSpare, CfgDataW'($urandom), 1'b1);
      write_reg(CfgNumImages, CfgDataW'(imgs), 1'b1);
      write_reg(CfgNumSimilar, sim_word, 1'b0);
      settings_tried++;

      calm = (p == 7);
      left = ItemsPerPhase;
      while (left > 0) begin
        burst = big ? $urandom_range(10, 30) : $urandom_range(0, 10);
        repeat (burst) begin
          if ($urandom_range(0, 99) < 15) idx = ImageW'($urandom);
          else idx = ImageW'($urandom_range(0, imgs - 1));
          send_vote(ModeHit, idx);
          if (32'(idx) < imgs && left > 0) left--;
        end
        // now and then the hits run on into the next burst
        if ($urandom_range(0, 9) != 0) begin
          send_vote(ModeReport, ImageW'($urandom));
          if (left > 0) left--;
          if ($urandom_range(0, 7) == 0) wait_drained(1'b0);
        end
      end
      calm = 1'b0;
    end

    wait_drained(1'b1);
    $display("%0d hits (%0d out of range) and %0d reports over %0d register settings,",
             hits_sent, hits_ignored, reports_sent, settings_tried);
    $display("%0d results compared, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && ranking_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
